FILE: hw/rtl/u8u16_pkg.sv
// package: payload types, decoder state and result types, constants for the utf-8 transcoder
package u8u16_pkg;

    localparam logic [15:0] REPL_RESET      = 16'h003F;
    localparam logic [15:0] HI_SURR_BASE    = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE    = 16'hDC00;
    localparam logic [20:0] SUPP_BASE       = 21'h010000;
    localparam logic [20:0] BMP_MAX         = 21'h00FFFF;
    localparam int          MAX_UNITS       = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        run_last;
        logic        string_end;
    } out_item_t;

    typedef struct packed {
        logic [7:0] lead_byte;
        logic [7:0] pend0;
        logic [7:0] pend1;
        logic [1:0] bytes_held;
        logic [1:0] bytes_needed;
    } dec_state_t;

    typedef struct packed {
        logic [MAX_UNITS-1:0][15:0] units;
        logic [2:0]                 count;
        logic                       string_end;
    } dec_result_t;

endpackage

FILE: hw/rtl/u8u16_decoder.sv
// combinational utf-8 byte decoder: next state and up to four utf-16 units per byte
module u8u16_decoder (
    input  u8u16_pkg::in_item_t    item,
    input  u8u16_pkg::dec_state_t  state,
    input  logic [15:0]            repl,
    output u8u16_pkg::dec_state_t  state_next,
    output u8u16_pkg::dec_result_t result
);

    logic        is_cont;
    logic        seq_open;
    logic        fresh_emit;
    logic [15:0] fresh_unit;
    logic        fresh_open;
    logic [1:0]  fresh_need;
    logic [2:0]  flush_cnt;
    logic [20:0] cp;
    logic [20:0] supp;
    logic [7:0]  b;
    logic        last;

    assign b        = item.in_byte;
    assign last     = item.last_byte;
    assign is_cont  = (b[7:6] == 2'b10);
    assign seq_open = (state.bytes_needed != 2'd0);

    // fresh lead decode
    always_comb begin
        fresh_emit = 1'b1;
        fresh_unit = repl;
        fresh_open = 1'b0;
        fresh_need = 2'd3;
        if (!b[7]) begin
            fresh_unit = {8'h00, b};
        end else if (is_cont || (b[7:3] == 5'b11111)) begin
            fresh_unit = repl;
        end else begin
            if (b[7:5] == 3'b110) begin
                fresh_need = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                fresh_need = 2'd2;
            end else begin
                fresh_need = 2'd3;
            end
            if (!last) begin
                fresh_emit = 1'b0;
                fresh_open = 1'b1;
            end
        end
    end

    // code point assembly
    always_comb begin
        case (state.bytes_needed)
            2'd1:    cp = {10'd0, state.lead_byte[4:0], b[5:0]};
            2'd2:    cp = {5'd0, state.lead_byte[3:0], state.pend0[5:0], b[5:0]};
            default: cp = {state.lead_byte[2:0], state.pend0[5:0], state.pend1[5:0], b[5:0]};
        endcase
    end

    assign supp      = cp - u8u16_pkg::SUPP_BASE;
    assign flush_cnt = {1'b0, state.bytes_held} + 3'd1;

    always_comb begin
        state_next        = state;
        result.units      = '0;
        result.count      = 3'd0;
        result.string_end = last;

        if (seq_open && is_cont) begin
            if (({1'b0, state.bytes_held} + 3'd1) >= {1'b0, state.bytes_needed}) begin
                // sequence complete
                state_next.bytes_needed = 2'd0;
                state_next.bytes_held   = 2'd0;
                if (cp <= u8u16_pkg::BMP_MAX) begin
                    result.units[0] = cp[15:0];
                    result.count    = 3'd1;
                end else begin
                    // high half keeps all eleven upper bits, wrapping at 16 bits
                    result.units[0] = u8u16_pkg::HI_SURR_BASE + {5'd0, supp[20:10]};
                    result.units[1] = u8u16_pkg::LO_SURR_BASE | {6'd0, supp[9:0]};
                    result.count    = 3'd2;
                end
            end else if (last) begin
                // truncated at string end: lead, held and this byte all replaced
                for (int i = 0; i < u8u16_pkg::MAX_UNITS; i++) begin
                    result.units[i] = repl;
                end
                result.count = {1'b0, state.bytes_held} + 3'd2;
            end else begin
                if (state.bytes_held[0]) begin
                    state_next.pend1 = b;
                end else begin
                    state_next.pend0 = b;
                end
                state_next.bytes_held = state.bytes_held + 2'd1;
            end
        end else begin
            // broken sequence flush (if open) followed by fresh decode
            for (int i = 0; i < u8u16_pkg::MAX_UNITS; i++) begin
                if (seq_open && (i < int'(flush_cnt))) begin
                    result.units[i] = repl;
                end else begin
                    result.units[i] = fresh_unit;
                end
            end
            result.count = (seq_open ? flush_cnt : 3'd0) + {2'd0, fresh_emit};
            state_next.bytes_held = 2'd0;
            if (fresh_open) begin
                state_next.lead_byte    = b;
                state_next.bytes_needed = fresh_need;
            end else begin
                state_next.bytes_needed = 2'd0;
            end
        end

        if (last) begin
            state_next.bytes_needed = 2'd0;
            state_next.bytes_held   = 2'd0;
        end
    end

endmodule

FILE: hw/rtl/utf8_to_utf16_transcoder.sv
// top level: streaming utf-8 to utf-16 transcoder with input register and result buffer
//
// Takes one utf-8 byte per transaction on s_ and gives utf-16 code units on m_, one per
// transaction. A byte is taken into an input register, decoded against the open-sequence
// state and loaded into a four-entry result buffer; the buffer then hands out its units
// one per cycle while m_ready is high. A byte accepted every cycle is sustained as long
// as each byte yields at most one unit and m_ready stays high; a byte that yields several
// units (2 for a surrogate pair, up to 4 for an error flush) holds the buffer until all are
// taken; bytes that yield no unit do not hold it. Complete sequences give their code point
// or a surrogate pair; invalid leads, broken and truncated sequences give the replacement
// unit for each byte involved. There are no overlong or surrogate checks. run_last marks
// the last unit caused by one byte and string_end marks the final unit of a string.
// The replacement unit (reset 0x003F) is written through cfg_wr_en / cfg_wr_data; the
// user must write it only while the block is idle, which the block does not enforce.
module utf8_to_utf16_transcoder (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [15:0]           cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  u8u16_pkg::in_item_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output u8u16_pkg::out_item_t  m_data
);

    // replacement unit register
    logic [15:0] repl_reg;

    // input register
    logic                 in_valid_reg;
    u8u16_pkg::in_item_t  in_item_reg;

    // decoder state
    u8u16_pkg::dec_state_t  state_reg;
    u8u16_pkg::dec_state_t  state_next;
    u8u16_pkg::dec_result_t dec_result;

    // result buffer
    logic                                   out_valid_reg;
    logic [u8u16_pkg::MAX_UNITS-1:0][15:0]  out_units_reg;
    logic [1:0]                             out_idx_reg;
    logic [1:0]                             out_last_idx_reg;
    logic                                   out_end_reg;

    logic out_final;
    logic out_drain;
    logic load;

    assign out_final = (out_idx_reg == out_last_idx_reg);
    assign out_drain = out_valid_reg && m_ready && out_final;
    // move the registered byte into the result buffer once the buffer frees up
    assign load      = in_valid_reg && (!out_valid_reg || out_drain);
    assign s_ready   = !in_valid_reg || load;

    u8u16_decoder u_decoder (
        .item       (in_item_reg),
        .state      (state_reg),
        .repl       (repl_reg),
        .state_next (state_next),
        .result     (dec_result)
    );

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repl_reg <= u8u16_pkg::REPL_RESET;
        end else if (cfg_wr_en) begin
            repl_reg <= cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    // decoder state advances when the byte leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (load) begin
            state_reg <= state_next;
        end
    end

    // result buffer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_idx_reg   <= 2'd0;
        end else if (load) begin
            // a byte with no result leaves the buffer empty
            out_valid_reg <= (dec_result.count != 3'd0);
            out_idx_reg   <= 2'd0;
        end else if (out_valid_reg && m_ready) begin
            if (out_final) begin
                out_valid_reg <= 1'b0;
            end else begin
                out_idx_reg <= out_idx_reg + 2'd1;
            end
        end
    end

    // result buffer payload
    always_ff @(posedge aclk) begin
        if (load) begin
            out_units_reg    <= dec_result.units;
            out_last_idx_reg <= 2'(dec_result.count - 3'd1);
            out_end_reg      <= dec_result.string_end;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_data.code_unit  = out_units_reg[out_idx_reg];
    assign m_data.run_last   = out_final;
    assign m_data.string_end = out_final && out_end_reg;

endmodule
